@@ rtl/a2k_pkg.sv @@
// shared types, key constants and the character lookup for the keystroke block
package a2k_pkg;

    localparam int CHAR_W      = 8;
    localparam int KEY_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2a;
    localparam logic [KEY_W-1:0] KEY_SPACE  = 7'h39;
    localparam logic [KEY_W-1:0] KEY_ENTER  = 7'h1c;
    localparam logic [KEY_W-1:0] KEY_TAB    = 7'h0f;
    localparam logic [KEY_W-1:0] KEY_BKSP   = 7'h0e;

    localparam logic [KEY_W-1:0] ALPHA_KEYS [26] = '{
        7'h1e, 7'h30, 7'h2e, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23, 7'h17, 7'h24,
        7'h25, 7'h26, 7'h32, 7'h31, 7'h18, 7'h19, 7'h10, 7'h13, 7'h1f, 7'h14,
        7'h16, 7'h2f, 7'h11, 7'h2d, 7'h15, 7'h2c
    };

    localparam logic [KEY_W-1:0] NUM_KEYS [10] = '{
        7'h0b, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0a
    };

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             shift;
    } a2k_cmd_t;

    typedef struct packed {
        logic     valid;
        a2k_cmd_t cmd;
    } a2k_class_t;

    function automatic a2k_class_t a2k_lookup(input logic [CHAR_W-1:0] c);
        a2k_class_t r;
        logic [CHAR_W-1:0] off_lower;
        logic [CHAR_W-1:0] off_upper;
        logic [CHAR_W-1:0] off_digit;
        off_lower = c - 8'h61;
        off_upper = c - 8'h41;
        off_digit = c - 8'h30;
        r.valid     = 1'b1;
        r.cmd.shift = 1'b0;
        r.cmd.key   = '0;
        if (c inside {[8'h61:8'h7a]}) begin
            r.cmd.key = ALPHA_KEYS[off_lower[4:0]];
        end else if (c inside {[8'h41:8'h5a]}) begin
            r.cmd.key   = ALPHA_KEYS[off_upper[4:0]];
            r.cmd.shift = 1'b1;
        end else if (c inside {[8'h30:8'h39]}) begin
            r.cmd.key = NUM_KEYS[off_digit[3:0]];
        end else begin
            case (c)
                8'h20:        r.cmd.key = KEY_SPACE;
                8'h0a, 8'h0d: r.cmd.key = KEY_ENTER;
                8'h09:        r.cmd.key = KEY_TAB;
                8'h08:        r.cmd.key = KEY_BKSP;
                8'h2d:        r.cmd.key = 7'h0c;
                8'h3d:        r.cmd.key = 7'h0d;
                8'h5b:        r.cmd.key = 7'h1a;
                8'h5d:        r.cmd.key = 7'h1b;
                8'h5c:        r.cmd.key = 7'h2b;
                8'h3b:        r.cmd.key = 7'h27;
                8'h27:        r.cmd.key = 7'h28;
                8'h60:        r.cmd.key = 7'h29;
                8'h2c:        r.cmd.key = 7'h33;
                8'h2e:        r.cmd.key = 7'h34;
                8'h2f:        r.cmd.key = 7'h35;
                8'h5f:        begin r.cmd.key = 7'h0c; r.cmd.shift = 1'b1; end
                8'h2b:        begin r.cmd.key = 7'h0d; r.cmd.shift = 1'b1; end
                8'h7b:        begin r.cmd.key = 7'h1a; r.cmd.shift = 1'b1; end
                8'h7d:        begin r.cmd.key = 7'h1b; r.cmd.shift = 1'b1; end
                8'h7c:        begin r.cmd.key = 7'h2b; r.cmd.shift = 1'b1; end
                8'h3a:        begin r.cmd.key = 7'h27; r.cmd.shift = 1'b1; end
                8'h22:        begin r.cmd.key = 7'h28; r.cmd.shift = 1'b1; end
                8'h7e:        begin r.cmd.key = 7'h29; r.cmd.shift = 1'b1; end
                8'h3c:        begin r.cmd.key = 7'h33; r.cmd.shift = 1'b1; end
                8'h3e:        begin r.cmd.key = 7'h34; r.cmd.shift = 1'b1; end
                8'h3f:        begin r.cmd.key = 7'h35; r.cmd.shift = 1'b1; end
                8'h29:        begin r.cmd.key = 7'h0b; r.cmd.shift = 1'b1; end
                8'h21:        begin r.cmd.key = 7'h02; r.cmd.shift = 1'b1; end
                8'h40:        begin r.cmd.key = 7'h03; r.cmd.shift = 1'b1; end
                8'h23:        begin r.cmd.key = 7'h04; r.cmd.shift = 1'b1; end
                8'h24:        begin r.cmd.key = 7'h05; r.cmd.shift = 1'b1; end
                8'h25:        begin r.cmd.key = 7'h06; r.cmd.shift = 1'b1; end
                8'h5e:        begin r.cmd.key = 7'h07; r.cmd.shift = 1'b1; end
                8'h26:        begin r.cmd.key = 7'h08; r.cmd.shift = 1'b1; end
                8'h2a:        begin r.cmd.key = 7'h09; r.cmd.shift = 1'b1; end
                8'h28:        begin r.cmd.key = 7'h0a; r.cmd.shift = 1'b1; end
                default:      r.valid = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

@@ rtl/a2k_front.sv @@
// front stage: accepts character beats, classifies them and hands keys to the queue
module a2k_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [a2k_pkg::CHAR_W-1:0]   char_code,
    output logic                         q_push,
    output a2k_pkg::a2k_cmd_t            q_cmd,
    input  logic                         q_full
);
    import a2k_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    a2k_cmd_t   cmd_reg;
    a2k_cmd_t   cmd_next;
    a2k_class_t cls;
    logic       take;

    assign cls    = a2k_lookup(char_code);
    assign q_push = valid_reg && !q_full;
    assign q_cmd  = cmd_reg;
    assign full   = valid_reg && q_full;
    assign take   = push && !full;

    always_comb
    begin
        valid_next = valid_reg && !q_push;
        cmd_next   = cmd_reg;
        if (take)
        begin
            // unmapped characters are dropped here
            valid_next = cls.valid;
            cmd_next   = cls.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

@@ rtl/a2k_queue.sv @@
// short command queue between the front and back stages
module a2k_queue #(
    parameter int DEPTH = a2k_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  a2k_pkg::a2k_cmd_t wr_cmd,
    output logic              q_full,
    input  logic              rd_en,
    output a2k_pkg::a2k_cmd_t rd_cmd,
    output logic              q_empty
);
    import a2k_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    a2k_cmd_t      mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

@@ rtl/a2k_back.sv @@
// back stage: steps each key command through its press and release events
module a2k_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  a2k_pkg::a2k_cmd_t           q_cmd,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [a2k_pkg::KEY_W-1:0]   key_number,
    output logic                        pressed,
    output logic                        last
);
    import a2k_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [1:0]           step_reg;
    logic [1:0]           step_next;
    a2k_cmd_t             cmd_reg;
    a2k_cmd_t             cmd_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     key_next;
    logic                 pressed_reg;
    logic                 pressed_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 slot_free;
    logic                 src_valid;
    a2k_cmd_t             src_cmd;
    logic [1:0]           src_step;
    logic [KEY_W-1:0]     ev_key;
    logic                 ev_pressed;
    logic                 ev_last;

    assign slot_free  = !out_valid_reg || pop;
    assign src_valid  = busy_reg || !q_empty;
    assign src_cmd    = busy_reg ? cmd_reg : q_cmd;
    assign src_step   = busy_reg ? step_reg : 2'd0;
    assign q_pop      = slot_free && !busy_reg && !q_empty;

    assign empty      = !out_valid_reg;
    assign key_number = key_reg;
    assign pressed    = pressed_reg;
    assign last       = last_reg;

    always_comb
    begin
        ev_key     = src_cmd.key;
        ev_pressed = 1'b0;
        ev_last    = 1'b0;
        if (src_cmd.shift)
        begin
            case (src_step)
                2'd0:    begin ev_key = KEY_LSHIFT; ev_pressed = 1'b1; end
                2'd1:    ev_pressed = 1'b1;
                2'd2:    ev_pressed = 1'b0;
                default: begin ev_key = KEY_LSHIFT; ev_last = 1'b1; end
            endcase
        end
        else
        begin
            ev_pressed = (src_step == 2'd0);
            ev_last    = (src_step != 2'd0);
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !pop;
        key_next       = key_reg;
        pressed_next   = pressed_reg;
        last_next      = last_reg;
        if (slot_free && src_valid)
        begin
            out_valid_next = 1'b1;
            key_next       = ev_key;
            pressed_next   = ev_pressed;
            last_next      = ev_last;
            cmd_next       = src_cmd;
            step_next      = src_step + 2'd1;
            busy_next      = !ev_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        pressed_reg <= pressed_next;
        last_reg    <= last_next;
    end

endmodule

@@ rtl/ascii_to_key_event_sequence.sv @@
// top level: character bytes in, US-layout scan code set 1 key events out
//
// Input channel: drive char_code and raise push; the beat is taken on a clock
// edge where push is high and full is low. Output channel: while empty is low,
// key_number, pressed and last show the oldest event; raise pop to take it.
// Each mapped character gives two events (key press, key release) or, for
// shifted characters, four (left shift press, key press, key release, left
// shift release). last marks the final event of a character. Unmapped bytes,
// including 0x80 and above, give no events and are dropped.
// Path: a character taken at the input passes the front stage register and the
// queue before its first event reaches the output register. Throughput: the
// output register gives one event per cycle while pop stays high; input beats
// are taken every cycle while the front stage and queue have room.
// When pop stays low the output register holds, the back stage stops, the
// queue fills and full rises. Reset (rst_n low) empties the queue, the front
// stage and the output register; no event is pending after it.
module ascii_to_key_event_sequence #(
    parameter int QUEUE_DEPTH = a2k_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [a2k_pkg::CHAR_W-1:0]  char_code,
    output logic                        empty,
    input  logic                        pop,
    output logic [a2k_pkg::KEY_W-1:0]   key_number,
    output logic                        pressed,
    output logic                        last
);
    import a2k_pkg::*;

    logic     q_push;
    a2k_cmd_t q_wr_cmd;
    logic     q_full;
    logic     q_pop;
    a2k_cmd_t q_rd_cmd;
    logic     q_empty;

    a2k_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .q_push    (q_push),
        .q_cmd     (q_wr_cmd),
        .q_full    (q_full)
    );

    a2k_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (q_wr_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (q_rd_cmd),
        .q_empty (q_empty)
    );

    a2k_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (q_rd_cmd),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .key_number (key_number),
        .pressed    (pressed),
        .last       (last)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the ASCII to scan code key event block
module testbench;

    import a2k_pkg::CHAR_W;
    import a2k_pkg::KEY_W;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CHARS = 305;
    localparam int MAX_IDLE = 12;

    localparam logic [KEY_W-1:0] LSHIFT_KEY = 7'h2a;
    localparam logic [KEY_W-1:0] SPACE_KEY  = 7'h39;
    localparam logic [KEY_W-1:0] ENTER_KEY  = 7'h1c;
    localparam logic [KEY_W-1:0] TAB_KEY    = 7'h0f;
    localparam logic [KEY_W-1:0] BKSP_KEY   = 7'h0e;

    localparam logic [CHAR_W-1:0] CHAR_BKSP = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB  = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0d;

    localparam logic [KEY_W-1:0] LETTER_KEYS [26] = '{
        7'h1e, 7'h30, 7'h2e, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23, 7'h17, 7'h24,
        7'h25, 7'h26, 7'h32, 7'h31, 7'h18, 7'h19, 7'h10, 7'h13, 7'h1f, 7'h14,
        7'h16, 7'h2f, 7'h11, 7'h2d, 7'h15, 7'h2c
    };
    localparam logic [KEY_W-1:0] DIGIT_KEYS [10] = '{
        7'h0b, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0a
    };
    localparam logic [CHAR_W-1:0] DIGIT_SYMBOLS [10] = '{
        8'h29, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28
    };
    localparam logic [CHAR_W-1:0] PUNCT_PLAIN [11] = '{
        8'h2d, 8'h3d, 8'h5b, 8'h5d, 8'h5c, 8'h3b, 8'h27, 8'h60, 8'h2c, 8'h2e, 8'h2f
    };
    localparam logic [CHAR_W-1:0] PUNCT_SHIFTED [11] = '{
        8'h5f, 8'h2b, 8'h7b, 8'h7d, 8'h7c, 8'h3a, 8'h22, 8'h7e, 8'h3c, 8'h3e, 8'h3f
    };
    localparam logic [KEY_W-1:0] PUNCT_KEYS [11] = '{
        7'h0c, 7'h0d, 7'h1a, 7'h1b, 7'h2b, 7'h27, 7'h28, 7'h29, 7'h33, 7'h34, 7'h35
    };

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             pressed;
        logic             last;
    } key_event_t;

    typedef struct {
        logic [CHAR_W-1:0] code;
        int unsigned       gap;
        bit                drain;
    } char_item_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              pop = 1'b0;
    logic [CHAR_W-1:0] char_code = '0;
    logic              full;
    logic              empty;
    logic [KEY_W-1:0]  key_number;
    logic              pressed;
    logic              last;

    char_item_t  char_backlog[$];
    key_event_t  pending_events[$];
    int unsigned mismatches = 0;
    int unsigned events_taken = 0;
    int unsigned cycles = 0;
    bit          push_taken = 1'b0;
    bit          pop_taken = 1'b0;

    ascii_to_key_event_sequence DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_code  (char_code),
        .empty      (empty),
        .pop        (pop),
        .key_number (key_number),
        .pressed    (pressed),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_key_events(input logic [CHAR_W-1:0] c);
        logic [KEY_W-1:0]  k;
        logic [CHAR_W-1:0] off;
        bit                shifted;
        bit                mapped;
        k = '0;
        off = '0;
        shifted = 1'b0;
        mapped = 1'b1;
        if (c >= 8'h61 && c <= 8'h7a) begin
            off = c - 8'h61;
            k = LETTER_KEYS[off[4:0]];
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            off = c - 8'h41;
            k = LETTER_KEYS[off[4:0]];
            shifted = 1'b1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            off = c - 8'h30;
            k = DIGIT_KEYS[off[3:0]];
        end else if (c == 8'h20) begin
            k = SPACE_KEY;
        end else if (c == CHAR_LF || c == CHAR_CR) begin
            k = ENTER_KEY;
        end else if (c == CHAR_TAB) begin
            k = TAB_KEY;
        end else if (c == CHAR_BKSP) begin
            k = BKSP_KEY;
        end else begin
            mapped = 1'b0;
            for (int i = 0; i < 11; i++) begin
                if (!mapped && PUNCT_PLAIN[i] == c) begin
                    k = PUNCT_KEYS[i];
                    mapped = 1'b1;
                end
            end
            for (int i = 0; i < 11; i++) begin
                if (!mapped && PUNCT_SHIFTED[i] == c) begin
                    k = PUNCT_KEYS[i];
                    shifted = 1'b1;
                    mapped = 1'b1;
                end
            end
            for (int i = 0; i < 10; i++) begin
                if (!mapped && DIGIT_SYMBOLS[i] == c) begin
                    k = DIGIT_KEYS[i];
                    shifted = 1'b1;
                    mapped = 1'b1;
                end
            end
        end
        if (mapped) begin
            if (shifted) begin
                pending_events.push_back('{LSHIFT_KEY, 1'b1, 1'b0});
                pending_events.push_back('{k, 1'b1, 1'b0});
                pending_events.push_back('{k, 1'b0, 1'b0});
                pending_events.push_back('{LSHIFT_KEY, 1'b0, 1'b1});
            end else begin
                pending_events.push_back('{k, 1'b1, 1'b0});
                pending_events.push_back('{k, 1'b0, 1'b1});
            end
        end
    endfunction

    // input beats are predicted and output beats checked at the rising edge
    always @(posedge clk)
    begin
        key_event_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[ascii_to_key_event_sequence] ERROR");
            $finish;
        end else if (rst_n) begin
            push_taken = push && !full;
            pop_taken = pop && !empty;
            if (push_taken)
                add_key_events(char_code);
            if (pop_taken) begin
                events_taken++;
                if (pending_events.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no event actual key=%h pressed=%b last=%b",
                             $time, key_number, pressed, last);
                end else begin
                    want = pending_events.pop_front();
                    if (key_number !== want.key) begin
                        mismatches++;
                        $display("%0t: key_number expected %h actual %h",
                                 $time, want.key, key_number);
                    end
                    if (pressed !== want.pressed) begin
                        mismatches++;
                        $display("%0t: pressed expected %b actual %b",
                                 $time, want.pressed, pressed);
                    end
                    if (last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, last);
                    end
                end
            end
        end
    end

    // sender
    bit          push_next = 1'b0;
    bit          gap_armed = 1'b0;
    int unsigned gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n) begin
            if (push_next && push_taken)
                push_next = 1'b0;
            if (!push_next && char_backlog.size() > 0) begin
                if (!gap_armed) begin
                    gap_left = char_backlog[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(char_backlog[0].drain && pending_events.size() > 0)) begin
                    char_code <= char_backlog[0].code;
                    void'(char_backlog.pop_front());
                    push_next = 1'b1;
                    gap_armed = 1'b0;
                end
            end
            push <= push_next;
        end
    end

    // receiver, idles in two out of three stretches of 64 events
    bit          pop_next = 1'b0;
    int unsigned stall_left = 0;

    always @(negedge clk)
    begin
        if (rst_n) begin
            if (pop_next && pop_taken)
                stall_left = ((events_taken / 64) % 3 != 0) ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall_left > 0) begin
                stall_left--;
                pop_next = 1'b0;
            end else begin
                pop_next = 1'b1;
            end
            pop <= pop_next;
        end
    end

    function automatic logic [CHAR_W-1:0] random_char();
        int unsigned pick;
        logic [CHAR_W-1:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            c = CHAR_W'($urandom_range(8'h20, 8'h7e));
        end else if (pick < 85) begin
            case ($urandom_range(0, 3))
                0: c = CHAR_BKSP;
                1: c = CHAR_TAB;
                2: c = CHAR_LF;
                default: c = CHAR_CR;
            endcase
        end else begin
            c = CHAR_W'($urandom_range(0, 255));
        end
        return c;
    endfunction

    initial
    begin
        logic [CHAR_W-1:0] directed [$];
        char_item_t        item;
        int unsigned       mode;
        directed = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h61, 8'h7a, 8'h41, 8'h5a, 8'h30,
                     8'h39, 8'h20, CHAR_LF, CHAR_CR, CHAR_TAB, CHAR_BKSP, 8'h2d,
                     8'h5f, 8'h2f, 8'h3f, 8'h29, 8'h28, 8'h7e, 8'h60, 8'h1f, 8'h07};
        foreach (directed[i]) begin
            item.code = directed[i];
            item.gap = 0;
            item.drain = 1'b0;
            char_backlog.push_back(item);
        end
        for (int i = 0; i < RANDOM_CHARS; i++) begin
            mode = (i / 60) % 3;
            item.code = random_char();
            item.gap = (mode == 1) ? $urandom_range(0, MAX_IDLE) :
                       (mode == 2) ? $urandom_range(0, 2) : 0;
            item.drain = (i == 0 || i == 200);
            char_backlog.push_back(item);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (char_backlog.size() > 0 || push)
            @(posedge clk);
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("[ascii_to_key_event_sequence] OK");
        else
            $display("[ascii_to_key_event_sequence] ERROR");
        $finish;
    end

endmodule
